>>> sv/plsc_pkg.sv
// ----------------------------------------------------------------------------
// Peak list similarity check package
// Shared widths, register indexes, reset values, ratio window and verdict codes.
// ----------------------------------------------------------------------------
package plsc_pkg;

   // Fixed field widths.
   localparam int COUNT_W     = 8;
   localparam int TOL_W       = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AMP_TOL     = 2'd0,
      CSR_FREQ_TOL    = 2'd1,
      CSR_COUNT_LIMIT = 2'd2,
      CSR_CLOSE_LIMIT = 2'd3
   } csr_index_type;

   // Register values after reset.
   localparam logic [TOL_W-1:0]   AMP_TOL_RST     = 16'd800;
   localparam logic [TOL_W-1:0]   FREQ_TOL_RST    = 16'd8;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 8'd10;
   localparam logic [COUNT_W-1:0] CLOSE_LIMIT_RST = 8'd3;

   // Ratio window 0.95 .. 1.05 as 19/20 .. 21/20.
   localparam int RATIO_LO  = 19;
   localparam int RATIO_DEN = 20;
   localparam int RATIO_HI  = 21;

   // Verdict codes.
   typedef enum logic [2:0] {
      VERDICT_COUNT_DIFF = 3'd0,
      VERDICT_AMP_DIFF   = 3'd1,
      VERDICT_FREQ_DIFF  = 3'd2,
      VERDICT_SIMILAR    = 3'd3,
      VERDICT_IDENTICAL  = 3'd4
   } verdict_type;

endpackage

>>> sv/peak_list_similarity_check_top.sv
// ----------------------------------------------------------------------------
// Peak list similarity check
// Compares a current peak list against a reference list, one peak pair per
// transfer, and reports a verdict at the end of each comparison.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one peak pair per transfer, together with both
//   peak counts and a last flag. Pair 0 is skipped, pair 1 sets the scale
//   bases, and later pairs below both counts are checked against the
//   tolerances. Only a transfer with req_last set produces a result on the
//   rsp_ channel: a verdict and a match flag.
//   Each pair passes through the input register, where it is folded into the
//   comparison state; a last pair's result is then registered in the output
//   register, which drives rsp_valid. Throughput is one pair per cycle unless
//   a last pair waits on a stalled receiver, set by the single state update
//   per cycle (two pairs of 2*VALUE_WIDTH products and compares).
//   When the receiver stalls, the output register holds its verdict; pairs
//   that are not last keep flowing, and a last pair waits in the input
//   register, which drops req_ready.
//   Reset loads the register defaults and clears the comparison state. The
//   csr_ port writes a register at every clock edge with csr_we high.
// ----------------------------------------------------------------------------
module peak_list_similarity_check_top import plsc_pkg::*; #(
   parameter int MAX_PEAKS   = 255,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // Input channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_cur_amp,
   input  logic [VALUE_WIDTH-1:0] req_cur_freq,
   input  logic [VALUE_WIDTH-1:0] req_ref_amp,
   input  logic [VALUE_WIDTH-1:0] req_ref_freq,
   input  logic [COUNT_W-1:0]     req_cur_count,
   input  logic [COUNT_W-1:0]     req_ref_count,
   input  logic                   req_last,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_verdict,
   output logic                   rsp_tracks_match
);

   localparam int PIDX_W    = $clog2(MAX_PEAKS + 1);
   localparam int CNT_CMP_W = (PIDX_W > COUNT_W) ? PIDX_W : COUNT_W;
   localparam int PROD_W    = 2 * VALUE_WIDTH;
   localparam int TOLP_W    = TOL_W + VALUE_WIDTH;
   localparam int DCMP_W    = (PROD_W > TOLP_W) ? PROD_W : TOLP_W;
   localparam int RATIO_W   = VALUE_WIDTH + 5;
   localparam logic [PIDX_W-1:0] PIDX_MAX = PIDX_W'(MAX_PEAKS);

   // True when |rv*bc - cv*br| > tol*br, or when the reference base is zero.
   function automatic logic pair_mismatch(input logic [VALUE_WIDTH-1:0] cv,
                                          input logic [VALUE_WIDTH-1:0] rv,
                                          input logic [VALUE_WIDTH-1:0] bc,
                                          input logic [VALUE_WIDTH-1:0] br,
                                          input logic [TOL_W-1:0]       tol);
      logic [PROD_W-1:0] prod_a;
      logic [PROD_W-1:0] prod_b;
      logic [PROD_W-1:0] prod_gap;
      logic [TOLP_W-1:0] limit;
      prod_a   = PROD_W'(rv) * PROD_W'(bc);
      prod_b   = PROD_W'(cv) * PROD_W'(br);
      prod_gap = (prod_a >= prod_b) ? (prod_a - prod_b) : (prod_b - prod_a);
      limit    = TOLP_W'(tol) * TOLP_W'(br);
      return (br == '0) || (DCMP_W'(prod_gap) > DCMP_W'(limit));
   endfunction

   // True when bc/br lies strictly inside the ratio window.
   function automatic logic ratio_close(input logic [VALUE_WIDTH-1:0] bc,
                                        input logic [VALUE_WIDTH-1:0] br);
      logic [RATIO_W-1:0] cur_scaled;
      logic [RATIO_W-1:0] ref_lo;
      logic [RATIO_W-1:0] ref_hi;
      cur_scaled = RATIO_W'(bc) * RATIO_W'(RATIO_DEN);
      ref_lo     = RATIO_W'(br) * RATIO_W'(RATIO_LO);
      ref_hi     = RATIO_W'(br) * RATIO_W'(RATIO_HI);
      return (br != '0) && (cur_scaled > ref_lo) && (cur_scaled < ref_hi);
   endfunction

   // Configuration registers
   logic [TOL_W-1:0]   amp_tol_ff;
   logic [TOL_W-1:0]   freq_tol_ff;
   logic [COUNT_W-1:0] count_limit_ff;
   logic [COUNT_W-1:0] close_limit_ff;

   // Input register
   logic                   a_valid_ff;
   logic [VALUE_WIDTH-1:0] a_cur_amp_ff;
   logic [VALUE_WIDTH-1:0] a_cur_freq_ff;
   logic [VALUE_WIDTH-1:0] a_ref_amp_ff;
   logic [VALUE_WIDTH-1:0] a_ref_freq_ff;
   logic [COUNT_W-1:0]     a_cur_count_ff;
   logic [COUNT_W-1:0]     a_ref_count_ff;
   logic                   a_last_ff;

   // Comparison state
   logic [PIDX_W-1:0]      pidx_ff;
   logic [PIDX_W-1:0]      pidx_in;
   logic [VALUE_WIDTH-1:0] base_cur_amp_ff;
   logic [VALUE_WIDTH-1:0] base_ref_amp_ff;
   logic [VALUE_WIDTH-1:0] base_cur_freq_ff;
   logic [VALUE_WIDTH-1:0] base_ref_freq_ff;
   logic [VALUE_WIDTH-1:0] base_cur_amp_in;
   logic [VALUE_WIDTH-1:0] base_ref_amp_in;
   logic [VALUE_WIDTH-1:0] base_cur_freq_in;
   logic [VALUE_WIDTH-1:0] base_ref_freq_in;
   logic                   amp_failed_ff;
   logic                   freq_failed_ff;
   logic                   amp_failed_in;
   logic                   freq_failed_in;

   // Output register
   logic                   rsp_valid_ff;
   verdict_type            verdict_ff;
   verdict_type            verdict_in;
   logic                   match_ff;

   logic                   a_advance;
   logic                   req_xfer;
   logic                   is_base;
   logic                   is_check;
   logic                   amp_mis;
   logic                   freq_mis;
   logic [CNT_CMP_W-1:0]   pidx_x;
   logic [COUNT_W-1:0]     count_diff;

   // The input register empties whenever its item can move on.
   assign a_advance = a_valid_ff && (!a_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || a_advance;
   assign req_xfer  = req_valid && req_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_tol_ff     <= AMP_TOL_RST;
         freq_tol_ff    <= FREQ_TOL_RST;
         count_limit_ff <= COUNT_LIMIT_RST;
         close_limit_ff <= CLOSE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_AMP_TOL:     amp_tol_ff     <= csr_wdata[TOL_W-1:0];
            CSR_FREQ_TOL:    freq_tol_ff    <= csr_wdata[TOL_W-1:0];
            CSR_COUNT_LIMIT: count_limit_ff <= csr_wdata[COUNT_W-1:0];
            CSR_CLOSE_LIMIT: close_limit_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: control.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   // Input register: payload.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_cur_amp_ff   <= req_cur_amp;
         a_cur_freq_ff  <= req_cur_freq;
         a_ref_amp_ff   <= req_ref_amp;
         a_ref_freq_ff  <= req_ref_freq;
         a_cur_count_ff <= req_cur_count;
         a_ref_count_ff <= req_ref_count;
         a_last_ff      <= req_last;
      end
   end

   // Classify the pair by its index.
   assign pidx_x   = CNT_CMP_W'(pidx_ff);
   assign is_base  = (pidx_ff == PIDX_W'(1));
   assign is_check = (pidx_ff >= PIDX_W'(2)) &&
                     (pidx_x < CNT_CMP_W'(a_cur_count_ff)) &&
                     (pidx_x < CNT_CMP_W'(a_ref_count_ff));

   // Tolerance checks by cross-multiplication.
   assign amp_mis  = pair_mismatch(a_cur_amp_ff, a_ref_amp_ff, base_cur_amp_ff,
                                   base_ref_amp_ff, amp_tol_ff);
   assign freq_mis = pair_mismatch(a_cur_freq_ff, a_ref_freq_ff, base_cur_freq_ff,
                                   base_ref_freq_ff, freq_tol_ff);

   // State after this pair; the verdict is taken from these values.
   always_comb begin
      base_cur_amp_in  = is_base ? a_cur_amp_ff  : base_cur_amp_ff;
      base_ref_amp_in  = is_base ? a_ref_amp_ff  : base_ref_amp_ff;
      base_cur_freq_in = is_base ? a_cur_freq_ff : base_cur_freq_ff;
      base_ref_freq_in = is_base ? a_ref_freq_ff : base_ref_freq_ff;
      amp_failed_in    = amp_failed_ff  || (is_check && amp_mis);
      freq_failed_in   = freq_failed_ff || (is_check && freq_mis);
      pidx_in          = (pidx_ff < PIDX_MAX) ? (pidx_ff + PIDX_W'(1)) : pidx_ff;
   end

   // Verdict in order of priority.
   assign count_diff = (a_cur_count_ff >= a_ref_count_ff) ?
                       (a_cur_count_ff - a_ref_count_ff) :
                       (a_ref_count_ff - a_cur_count_ff);

   always_comb begin
      if (count_diff >= count_limit_ff) begin
         verdict_in = VERDICT_COUNT_DIFF;
      end else if (amp_failed_in) begin
         verdict_in = VERDICT_AMP_DIFF;
      end else if (freq_failed_in) begin
         verdict_in = VERDICT_FREQ_DIFF;
      end else if ((pidx_in >= PIDX_W'(2)) && (count_diff < close_limit_ff) &&
                   ratio_close(base_cur_amp_in, base_ref_amp_in) &&
                   ratio_close(base_cur_freq_in, base_ref_freq_in)) begin
         verdict_in = VERDICT_IDENTICAL;
      end else begin
         verdict_in = VERDICT_SIMILAR;
      end
   end

   // Comparison state update; a last pair returns it to its reset value.
   always_ff @(posedge clock) begin
      if (reset || (a_advance && a_last_ff)) begin
         pidx_ff          <= '0;
         base_cur_amp_ff  <= '0;
         base_ref_amp_ff  <= '0;
         base_cur_freq_ff <= '0;
         base_ref_freq_ff <= '0;
         amp_failed_ff    <= 1'b0;
         freq_failed_ff   <= 1'b0;
      end else if (a_advance) begin
         pidx_ff          <= pidx_in;
         base_cur_amp_ff  <= base_cur_amp_in;
         base_ref_amp_ff  <= base_ref_amp_in;
         base_cur_freq_ff <= base_cur_freq_in;
         base_ref_freq_ff <= base_ref_freq_in;
         amp_failed_ff    <= amp_failed_in;
         freq_failed_ff   <= freq_failed_in;
      end
   end

   // Output register: control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_advance && a_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register: payload.
   always_ff @(posedge clock) begin
      if (a_advance && a_last_ff) begin
         verdict_ff <= verdict_in;
         match_ff   <= (verdict_in == VERDICT_SIMILAR) ||
                       (verdict_in == VERDICT_IDENTICAL);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_tracks_match = match_ff;

endmodule

>>> sv/plsc_checker.sv
// ----------------------------------------------------------------------------
// Peak list similarity check port checker
// Watches the result channel of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
module plsc_checker import plsc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_verdict,
   input logic       rsp_tracks_match
);

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The match flag agrees with the verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tracks_match ==
                     ((rsp_verdict == VERDICT_SIMILAR) ||
                      (rsp_verdict == VERDICT_IDENTICAL))))
      else $error("match flag disagrees with verdict");

   // Only defined verdict codes are reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict <= VERDICT_IDENTICAL))
      else $error("undefined verdict code");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_verdict) && $stable(rsp_tracks_match)))
      else $error("stalled result changed");

endmodule

bind peak_list_similarity_check_top plsc_checker u_plsc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_verdict      (rsp_verdict),
   .rsp_tracks_match (rsp_tracks_match)
);

>>> test/tb_peak_list_similarity_check_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak list similarity check testbench
// Streams directed and random peak lists through the block under several
// register settings and flow-control patterns. Every verdict is predicted
// from the accepted pairs, and each result transfer is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_peak_list_similarity_check_top;
   import plsc_pkg::*;

   localparam int VW        = 16;
   localparam int MAX_PEAKS = 255;
   localparam int QUIET_MAX = 3000;
   localparam int HOLD_SPAN = 200;
   localparam int SETTLE    = 4;

   // One peak pair as it travels on the input channel.
   typedef struct {
      logic [VW-1:0]      cur_amp;
      logic [VW-1:0]      cur_freq;
      logic [VW-1:0]      ref_amp;
      logic [VW-1:0]      ref_freq;
      logic [COUNT_W-1:0] cur_count;
      logic [COUNT_W-1:0] ref_count;
      logic               last;
   } peak_pair_type;

   // One predicted verdict.
   typedef struct {
      verdict_type verdict;
      logic        tracks_match;
   } verdict_note_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_AMP_TOL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [VW-1:0]          req_cur_amp = '0;
   logic [VW-1:0]          req_cur_freq = '0;
   logic [VW-1:0]          req_ref_amp = '0;
   logic [VW-1:0]          req_ref_freq = '0;
   logic [COUNT_W-1:0]     req_cur_count = '0;
   logic [COUNT_W-1:0]     req_ref_count = '0;
   logic                   req_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_verdict;
   logic                   rsp_tracks_match;

   // Stimulus and expectation stores.
   peak_pair_type    pending_pairs[$];
   verdict_note_type verdicts_due[$];

   // Flow-control knobs, set per phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_granted = 0;
   int unsigned hold_left = 0;

   logic        req_taken = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned error_count = 0;

   // Predictor configuration.
   logic [TOL_W-1:0]   amp_tol_cfg = AMP_TOL_RST;
   logic [TOL_W-1:0]   freq_tol_cfg = FREQ_TOL_RST;
   logic [COUNT_W-1:0] count_limit_cfg = COUNT_LIMIT_RST;
   logic [COUNT_W-1:0] close_limit_cfg = CLOSE_LIMIT_RST;

   // Predictor comparison state.
   logic [7:0]    cmp_index = '0;
   logic [VW-1:0] amp_base_cur = '0;
   logic [VW-1:0] amp_base_ref = '0;
   logic [VW-1:0] freq_base_cur = '0;
   logic [VW-1:0] freq_base_ref = '0;
   logic          amp_bad = 1'b0;
   logic          freq_bad = 1'b0;

   peak_list_similarity_check_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cur_amp      (req_cur_amp),
      .req_cur_freq     (req_cur_freq),
      .req_ref_amp      (req_ref_amp),
      .req_ref_freq     (req_ref_freq),
      .req_cur_count    (req_cur_count),
      .req_ref_count    (req_ref_count),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_tracks_match (rsp_tracks_match)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // A pair is off when the cross-multiplied difference exceeds the scaled
   // tolerance; a zero reference base always counts as off.
   function automatic logic outside_tolerance(input logic [VW-1:0] cv, rv, bc, br,
                                              input logic [TOL_W-1:0] tol);
      logic [2*VW-1:0] lhs;
      logic [2*VW-1:0] rhs;
      logic [2*VW-1:0] gap;
      logic [2*VW-1:0] bound;
      if (br == 0) return 1'b1;
      lhs   = rv * bc;
      rhs   = cv * br;
      gap   = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
      bound = tol * br;
      return gap > bound;
   endfunction

   // True when bc/br lies strictly between 0.95 and 1.05.
   function automatic logic ratio_near_one(input logic [VW-1:0] bc, br);
      logic [31:0] scaled_cur;
      if (br == 0) return 1'b0;
      scaled_cur = RATIO_DEN * bc;
      return (scaled_cur > RATIO_LO * br) && (scaled_cur < RATIO_HI * br);
   endfunction

   // Fold one accepted pair into the predicted comparison state.
   task automatic fold_pair(input peak_pair_type p);
      logic [COUNT_W-1:0] count_gap;
      verdict_type        v;
      if (cmp_index == 1) begin
         amp_base_cur  = p.cur_amp;
         amp_base_ref  = p.ref_amp;
         freq_base_cur = p.cur_freq;
         freq_base_ref = p.ref_freq;
      end else if (cmp_index >= 2 && cmp_index < p.cur_count && cmp_index < p.ref_count) begin
         if (outside_tolerance(p.cur_amp, p.ref_amp, amp_base_cur, amp_base_ref, amp_tol_cfg))
            amp_bad = 1'b1;
         if (outside_tolerance(p.cur_freq, p.ref_freq, freq_base_cur, freq_base_ref,
                               freq_tol_cfg))
            freq_bad = 1'b1;
      end
      if (cmp_index < MAX_PEAKS) cmp_index++;
      if (p.last) begin
         count_gap = (p.cur_count >= p.ref_count) ? p.cur_count - p.ref_count
                                                  : p.ref_count - p.cur_count;
         if (count_gap >= count_limit_cfg) v = VERDICT_COUNT_DIFF;
         else if (amp_bad) v = VERDICT_AMP_DIFF;
         else if (freq_bad) v = VERDICT_FREQ_DIFF;
         else if (cmp_index >= 2 && count_gap < close_limit_cfg &&
                  ratio_near_one(amp_base_cur, amp_base_ref) &&
                  ratio_near_one(freq_base_cur, freq_base_ref))
            v = VERDICT_IDENTICAL;
         else v = VERDICT_SIMILAR;
         verdicts_due.push_back('{v, (v == VERDICT_SIMILAR) || (v == VERDICT_IDENTICAL)});
         // The next comparison starts from a clean state.
         cmp_index     = '0;
         amp_base_cur  = '0;
         amp_base_ref  = '0;
         freq_base_cur = '0;
         freq_base_ref = '0;
         amp_bad       = 1'b0;
         freq_bad      = 1'b0;
      end
   endtask

   function automatic logic [VW-1:0] clip_value(input longint v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[VW-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] clip_count(input int v);
      if (v < 0) return '0;
      if (v > 255) return '1;
      return v[COUNT_W-1:0];
   endfunction

   // Scale base: mostly large, sometimes small, now and then zero.
   function automatic logic [VW-1:0] pick_base();
      case ($urandom_range(15))
         0:       return '0;
         1, 2:    return VW'($urandom_range(300, 1));
         default: return VW'($urandom_range(65535, 1));
      endcase
   endfunction

   // Current-track base within about ten percent of the reference base.
   function automatic logic [VW-1:0] near_base(input logic [VW-1:0] b);
      if ($urandom_range(3) == 0) return b;
      return clip_value(longint'(b) * $urandom_range(110, 90) / 100);
   endfunction

   // Current value that follows the reference through the base ratio, with an
   // error mostly inside the tolerance and sometimes just beyond it.
   function automatic logic [VW-1:0] scaled_partner(input logic [VW-1:0] rv, bc, br,
                                                    input logic [TOL_W-1:0] tol);
      longint centre;
      longint offset;
      if (br == 0) return VW'($urandom);
      centre = (longint'(rv) * longint'(bc)) / longint'(br);
      if ($urandom_range(24) == 0) offset = longint'(tol) + 1 + $urandom_range(500);
      else offset = $urandom_range(tol);
      if ($urandom_range(1) == 1) offset = -offset;
      return clip_value(centre + offset);
   endfunction

   task automatic queue_pair(input logic [VW-1:0] ca, cf, ra, rf,
                             input logic [COUNT_W-1:0] cc, rc, input logic last);
      pending_pairs.push_back('{ca, cf, ra, rf, cc, rc, last});
   endtask

   // Queue one whole peak list of n pairs. A noisy list carries random
   // values and may change its counts on the way.
   task automatic queue_peak_list(input int n, input bit noisy);
      peak_pair_type p;
      int            centre_count;
      int            dev;
      logic [VW-1:0] bca, bra, bcf, brf;
      centre_count = n - 1 + $urandom_range(2);
      dev          = $urandom_range(6);
      if (noisy || $urandom_range(7) == 0) begin
         p.cur_count = COUNT_W'($urandom);
         p.ref_count = COUNT_W'($urandom);
      end else begin
         p.cur_count = clip_count(centre_count);
         p.ref_count = clip_count(centre_count + dev - 3);
      end
      bra = pick_base();
      bca = near_base(bra);
      brf = pick_base();
      bcf = near_base(brf);
      for (int k = 0; k < n; k++) begin
         p.last = (k == n - 1);
         if (noisy) begin
            p.cur_amp  = VW'($urandom);
            p.cur_freq = VW'($urandom);
            p.ref_amp  = VW'($urandom);
            p.ref_freq = VW'($urandom);
            if ($urandom_range(3) == 0) begin
               p.cur_count = COUNT_W'($urandom);
               p.ref_count = COUNT_W'($urandom);
            end
         end else if (k == 1) begin
            p.cur_amp  = bca;
            p.ref_amp  = bra;
            p.cur_freq = bcf;
            p.ref_freq = brf;
         end else begin
            p.ref_amp  = VW'($urandom_range(59000));
            p.ref_freq = VW'($urandom_range(59000));
            p.cur_amp  = scaled_partner(p.ref_amp, bca, bra, amp_tol_cfg);
            p.cur_freq = scaled_partner(p.ref_freq, bcf, brf, freq_tol_cfg);
         end
         pending_pairs.push_back(p);
      end
   endtask

   // Write one register and mirror it in the predictor.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AMP_TOL:     amp_tol_cfg = val;
         CSR_FREQ_TOL:    freq_tol_cfg = val;
         CSR_COUNT_LIMIT: count_limit_cfg = val[COUNT_W-1:0];
         CSR_CLOSE_LIMIT: close_limit_cfg = val[COUNT_W-1:0];
      endcase
   endtask

   // The count registers get random upper data bits, which must be dropped.
   task automatic set_regs(input logic [TOL_W-1:0] amp_tol, freq_tol,
                           input logic [COUNT_W-1:0] count_limit, close_limit);
      write_reg(CSR_AMP_TOL, amp_tol);
      write_reg(CSR_FREQ_TOL, freq_tol);
      write_reg(CSR_COUNT_LIMIT, {8'($urandom), count_limit});
      write_reg(CSR_CLOSE_LIMIT, {8'($urandom), close_limit});
   endtask

   // Wait until every queued pair is sent and every verdict has come back.
   task automatic drain();
      while (pending_pairs.size() > 0 || req_valid || verdicts_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Sender: offers the next queued pair once the previous one is transferred.
   always @(negedge clock) begin
      peak_pair_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_pair = pending_pairs.pop_front();
            req_cur_amp   <= next_pair.cur_amp;
            req_cur_freq  <= next_pair.cur_freq;
            req_ref_amp   <= next_pair.ref_amp;
            req_ref_freq  <= next_pair.ref_freq;
            req_cur_count <= next_pair.cur_count;
            req_ref_count <= next_pair.ref_count;
            req_last      <= next_pair.last;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_granted != hold_requests) begin
         hold_granted = hold_requests;
         hold_left    = HOLD_SPAN;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: checks result transfers, predicts from input transfers and
   // ends the run when nothing moves for too long.
   always @(posedge clock) begin
      peak_pair_type    seen;
      verdict_note_type due;
      req_taken = 1'b0;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result verdict=%0d tracks_match=%0b",
                           $realtime, rsp_verdict, rsp_tracks_match);
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_verdict !== due.verdict || rsp_tracks_match !== due.tracks_match) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: expected verdict=%0d tracks_match=%0b, got %0d/%0b",
                              $realtime, due.verdict, due.tracks_match,
                              rsp_verdict, rsp_tracks_match);
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken      = 1'b1;
            seen.cur_amp   = req_cur_amp;
            seen.cur_freq  = req_cur_freq;
            seen.ref_amp   = req_ref_amp;
            seen.ref_freq  = req_ref_freq;
            seen.cur_count = req_cur_count;
            seen.ref_count = req_ref_count;
            seen.last      = req_last;
            fold_pair(seen);
         end
         if ((rsp_valid && rsp_ready) || req_taken) quiet_cycles = 0;
         else quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      int budget;
      int n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lists under the reset register values.
      // A single pair: nothing checked, the verdict rests on counts only.
      queue_pair(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b1);
      // Two pairs with equal bases: identical on the base pair alone.
      queue_pair(16'd7, 16'd7, 16'd7, 16'd7, 8'd2, 8'd2, 1'b0);
      queue_pair(16'd1000, 16'd500, 16'd1000, 16'd500, 8'd2, 8'd2, 1'b1);
      // Largest values and counts.
      queue_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 1'b0);
      queue_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 1'b0);
      queue_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 1'b0);
      queue_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 1'b1);
      // Zero reference amplitude base: the checked pair is a mismatch.
      queue_pair(16'd1, 16'd1, 16'd1, 16'd1, 8'd5, 8'd5, 1'b0);
      queue_pair(16'd300, 16'd200, 16'd0, 16'd200, 8'd5, 8'd5, 1'b0);
      queue_pair(16'd5, 16'd5, 16'd5, 16'd5, 8'd5, 8'd5, 1'b1);
      // Frequency far off while amplitude agrees.
      queue_pair(16'd0, 16'd0, 16'd0, 16'd0, 8'd3, 8'd3, 1'b0);
      queue_pair(16'd100, 16'd100, 16'd100, 16'd100, 8'd3, 8'd3, 1'b0);
      queue_pair(16'd50, 16'd900, 16'd50, 16'd100, 8'd3, 8'd3, 1'b1);
      // Counts far apart.
      queue_pair(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'd255, 8'd0, 1'b0);
      queue_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'd255, 8'd0, 1'b1);
      // Consistent pairs with an amplitude ratio of 1.2: similar only.
      queue_pair(16'd0, 16'd0, 16'd0, 16'd0, 8'd3, 8'd3, 1'b0);
      queue_pair(16'd1200, 16'd1000, 16'd1000, 16'd1000, 8'd3, 8'd3, 1'b0);
      queue_pair(16'd600, 16'd40, 16'd500, 16'd40, 8'd3, 8'd3, 1'b1);
      // Ratio exactly on the lower edge of the window.
      queue_pair(16'd0, 16'd0, 16'd0, 16'd0, 8'd2, 8'd2, 1'b0);
      queue_pair(16'd19, 16'd20, 16'd20, 16'd20, 8'd2, 8'd2, 1'b1);
      // All zero: the zero base fails the ratio test.
      queue_pair(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
      queue_pair(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
      queue_pair(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b1);
      // Count difference equal to the close limit: not identical.
      queue_pair(16'd9, 16'd9, 16'd9, 16'd9, 8'd4, 8'd7, 1'b0);
      queue_pair(16'd400, 16'd400, 16'd400, 16'd400, 8'd4, 8'd7, 1'b1);
      drain();

      // Random phases, each with its own registers and flow control.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               set_regs(AMP_TOL_RST, FREQ_TOL_RST, COUNT_LIMIT_RST, CLOSE_LIMIT_RST);
               send_idle_pct = 0;  recv_stall_pct = 0;  budget = 80;
            end
            1: begin
               set_regs('1, '1, '1, '1);
               send_idle_pct = 81; recv_stall_pct = 0;  budget = 80;
            end
            2: begin
               set_regs('0, '0, '1, '0);
               send_idle_pct = 0;  recv_stall_pct = 81; budget = 80;
            end
            3: begin
               set_regs(TOL_W'($urandom), TOL_W'($urandom_range(200)),
                        COUNT_W'($urandom_range(255, 1)), COUNT_W'($urandom));
               send_idle_pct = 38; recv_stall_pct = 38; budget = 80;
            end
            4: begin
               set_regs(16'd300, 16'd40, 8'd6, 8'd2);
               send_idle_pct = 0;  recv_stall_pct = 0;  budget = 50;
            end
            default: begin
               set_regs(16'd1200, 16'd20, '0, '1);
               send_idle_pct = 38; recv_stall_pct = 38; budget = 30;
            end
         endcase
         while (budget > 0) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(10, 1);
            queue_peak_list(n, $urandom_range(5) == 0);
            budget -= n;
         end
         // Hold the receiver off while the sender keeps pushing pairs.
         if (phase == 0) hold_requests++;
         // One list long enough to saturate the pair index.
         if (phase == 4) queue_peak_list(258, 1'b0);
         drain();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
